// ===== rtl/core/cor_pkg.sv =====
// Shared types and constants for the circle overlay rasterizer.
`timescale 1ns / 1ps

package cor_pkg;

	localparam int COORD_W    = 20;
	localparam int RAD_W      = 19;
	localparam int PIX_W      = 9;
	localparam int CHAR_W     = 8;
	localparam int FUNC_W     = 2;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [CHAR_W-1:0] KIND_FILLED  = 8'h43;
	localparam logic [CHAR_W-1:0] KIND_OUTLINE = 8'h63;
	localparam logic [CHAR_W-1:0] BG_RESET     = 8'h20;

	typedef enum logic [FUNC_W-1:0] {
		FN_ADD   = 2'd0,
		FN_QUERY = 2'd1,
		FN_CLEAR = 2'd2
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK         = 2'd0,
		ST_BAD_CIRCLE = 2'd1,
		ST_FULL       = 2'd2,
		ST_OUTSIDE    = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_BG     = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic [RAD_W-1:0]          r;
		logic                      filled;
		logic [CHAR_W-1:0]         paint;
	} entry_t;

endpackage

// ===== rtl/core/cor_ifs.sv =====
// Request, response and configuration channel interfaces.
`timescale 1ns / 1ps

interface cor_req_if import cor_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [FUNC_W-1:0]         func;
	logic signed [COORD_W-1:0] center_x;
	logic signed [COORD_W-1:0] center_y;
	logic signed [COORD_W-1:0] radius;
	logic [CHAR_W-1:0]         kind_char;
	logic [CHAR_W-1:0]         paint_char;
	logic [PIX_W-1:0]          pixel_x;
	logic [PIX_W-1:0]          pixel_y;

	modport source (output valid, func, center_x, center_y, radius, kind_char, paint_char,
		pixel_x, pixel_y, input ready);
	modport sink (input valid, func, center_x, center_y, radius, kind_char, paint_char,
		pixel_x, pixel_y, output ready);
endinterface

interface cor_rsp_if import cor_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] pixel_char;
	logic [STAT_W-1:0] status;

	modport source (output valid, pixel_char, status, input ready);
	modport sink (input valid, pixel_char, status, output ready);
endinterface

interface cor_cfg_if import cor_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/circle_overlay_rasterizer_top.sv =====
// Circle overlay rasterizer: circle store, pixel query sequencer and config registers.
`timescale 1ns / 1ps

// Holds up to MAX_CIRCLES circles in an on-chip memory and answers one request at a
// time. Add, clear, rejected and outside-canvas requests go straight to the done state,
// which loads the response into the output register and returns to idle. A pixel query
// inside the canvas walks the stored circles in order and then goes to the done state.
// Each circle is read from the store and then passes four times through a single squaring
// multiplier (dx, dy, radius, radius minus one) before the coverage compare. The request
// side is ready only while the sequencer is idle. A finished response waits in its output
// register and does not hold off the next request. If the register is still full when
// that request finishes, the sequencer holds in its done state until the earlier response
// is taken. Configuration writes are always taken and must be issued while idle.

module circle_overlay_rasterizer_top import cor_pkg::*; #(
	parameter int MAX_CIRCLES = 64,
	parameter int MAX_CANVAS  = 300,
	parameter int FRAC_BITS   = 8
) (
	input logic       clk,
	input logic       arst_n,
	cor_req_if.sink   req,
	cor_rsp_if.source rsp,
	cor_cfg_if.sink   cfg
);

	localparam int IDX_W    = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
	localparam int CNT_W    = $clog2(MAX_CIRCLES + 1);
	localparam int CANVAS_W = $clog2(MAX_CANVAS + 1);
	localparam int CMP_W    = (CANVAS_W > PIX_W) ? CANVAS_W : PIX_W;
	localparam int FIX_W    = PIX_W + FRAC_BITS + 1;
	localparam int DIFF_W   = ((FIX_W > COORD_W) ? FIX_W : COORD_W) + 1;
	localparam int SQ_W     = 2 * DIFF_W;
	localparam int D2_W     = SQ_W + 1;

	localparam logic signed [DIFF_W-1:0] ONE = DIFF_W'(1) << FRAC_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_DIFF, S_MX, S_MY, S_MR, S_MR1, S_CMP, S_DONE
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  count_q;
	logic [PIX_W-1:0]  width_q, height_q;
	logic [CHAR_W-1:0] bg_q;
	logic [CHAR_W-1:0] res_char_q, out_char_q;
	status_t           res_stat_q, out_stat_q;
	logic              out_vld_q;

	entry_t mem_q [MAX_CIRCLES];
	entry_t rd_q;

	logic [PIX_W-1:0]         px_q, py_q;
	logic signed [DIFF_W-1:0] dx_q, dy_q, r_q, r1_q;
	logic                     r1_neg_q, filled_q;
	logic [CHAR_W-1:0]        paint_q;
	logic [SQ_W-1:0]          prod_q, r2_q;
	logic [D2_W-1:0]          d2_q;

	logic [CMP_W-1:0]         w_eff, h_eff;
	logic                     outside, bad, full, in_acc, wr_en, last, hit, out_load;
	logic signed [DIFF_W-1:0] px_fix, py_fix, r_ext, mul_op;
	logic signed [SQ_W-1:0]   sq;
	entry_t                   new_entry;

	assign req.ready      = (state_q == S_IDLE);
	assign cfg.ready      = 1'b1;
	assign rsp.valid      = out_vld_q;
	assign rsp.pixel_char = out_char_q;
	assign rsp.status     = out_stat_q;

	assign in_acc = req.valid && req.ready;

	always_comb begin
		w_eff = (CMP_W'(width_q) > CMP_W'(MAX_CANVAS)) ? CMP_W'(MAX_CANVAS) : CMP_W'(width_q);
		h_eff = (CMP_W'(height_q) > CMP_W'(MAX_CANVAS)) ? CMP_W'(MAX_CANVAS) : CMP_W'(height_q);
		outside = (CMP_W'(req.pixel_x) >= w_eff) || (CMP_W'(req.pixel_y) >= h_eff);
		bad = req.radius[COORD_W-1] || (req.radius == '0) ||
			!((req.kind_char == KIND_FILLED) || (req.kind_char == KIND_OUTLINE));
		full = (count_q == CNT_W'(MAX_CIRCLES));
		wr_en = in_acc && (req.func == FN_ADD) && !bad && !full;
		last = (CNT_W'(idx_q) == count_q - CNT_W'(1));
		out_load = (state_q == S_DONE) && (!out_vld_q || rsp.ready);
		new_entry.cx     = req.center_x;
		new_entry.cy     = req.center_y;
		new_entry.r      = req.radius[RAD_W-1:0];
		new_entry.filled = (req.kind_char == KIND_FILLED);
		new_entry.paint  = req.paint_char;
	end

	// Store: one write port for appends, one registered read port for the query walk.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[count_q[IDX_W-1:0]] <= new_entry;
		end
		rd_q <= mem_q[idx_q];
	end

	// Shared squaring unit and its operand select.
	always_comb begin
		case (state_q)
			S_MX:    mul_op = dx_q;
			S_MY:    mul_op = dy_q;
			S_MR:    mul_op = r_q;
			default: mul_op = r1_q;
		endcase
		sq = mul_op * mul_op;
		px_fix = $signed(DIFF_W'(px_q)) <<< FRAC_BITS;
		py_fix = $signed(DIFF_W'(py_q)) <<< FRAC_BITS;
		r_ext  = $signed(DIFF_W'(rd_q.r));
	end

	// Outline covers when r2 > d2 > (r-1)^2; the lower bound drops when r-1 is negative.
	always_comb begin
		if (filled_q) begin
			hit = d2_q <= D2_W'(r2_q);
		end else begin
			hit = (d2_q < D2_W'(r2_q)) && (r1_neg_q || (d2_q > D2_W'(prod_q)));
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			px_q <= req.pixel_x;
			py_q <= req.pixel_y;
		end
		if (state_q == S_DIFF) begin
			dx_q     <= px_fix - DIFF_W'(rd_q.cx);
			dy_q     <= py_fix - DIFF_W'(rd_q.cy);
			r_q      <= r_ext;
			r1_q     <= r_ext - ONE;
			r1_neg_q <= (r_ext < ONE);
			filled_q <= rd_q.filled;
			paint_q  <= rd_q.paint;
		end
		prod_q <= SQ_W'($unsigned(sq));
		case (state_q)
			S_MY:    d2_q <= D2_W'(prod_q);
			S_MR:    d2_q <= d2_q + D2_W'(prod_q);
			default: d2_q <= d2_q;
		endcase
		if (state_q == S_MR1) begin
			r2_q <= prod_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			idx_q      <= '0;
			count_q    <= '0;
			width_q    <= '0;
			height_q   <= '0;
			bg_q       <= BG_RESET;
			res_char_q <= '0;
			res_stat_q <= ST_OK;
			out_char_q <= '0;
			out_stat_q <= ST_OK;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_WIDTH:  width_q  <= cfg.data[PIX_W-1:0];
					REG_HEIGHT: height_q <= cfg.data[PIX_W-1:0];
					REG_BG:     bg_q     <= cfg.data[CHAR_W-1:0];
					default:    ;
				endcase
			end
			// Load a finished result, else drop the one just taken.
			if (out_load) begin
				out_vld_q  <= 1'b1;
				out_char_q <= res_char_q;
				out_stat_q <= res_stat_q;
			end else if (rsp.valid && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						case (req.func)
							FN_ADD: begin
								res_char_q <= '0;
								state_q    <= S_DONE;
								if (bad) begin
									res_stat_q <= ST_BAD_CIRCLE;
								end else if (full) begin
									res_stat_q <= ST_FULL;
								end else begin
									res_stat_q <= ST_OK;
									count_q    <= count_q + CNT_W'(1);
								end
							end
							FN_QUERY: begin
								if (outside) begin
									res_char_q <= '0;
									res_stat_q <= ST_OUTSIDE;
									state_q    <= S_DONE;
								end else begin
									res_char_q <= bg_q;
									res_stat_q <= ST_OK;
									idx_q      <= '0;
									if (count_q != '0) begin
										state_q <= S_RD;
									end else begin
										state_q <= S_DONE;
									end
								end
							end
							FN_CLEAR: begin
								res_char_q <= '0;
								res_stat_q <= ST_OK;
								count_q    <= '0;
								state_q    <= S_DONE;
							end
							default: begin
								res_char_q <= '0;
								res_stat_q <= ST_OK;
								state_q    <= S_DONE;
							end
						endcase
					end
				end
				S_RD:   state_q <= S_DIFF;
				S_DIFF: state_q <= S_MX;
				S_MX:   state_q <= S_MY;
				S_MY:   state_q <= S_MR;
				S_MR:   state_q <= S_MR1;
				S_MR1:  state_q <= S_CMP;
				S_CMP: begin
					if (hit) begin
						res_char_q <= paint_q;
					end
					if (last) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_RD;
					end
				end
				S_DONE: begin
					// Hold the result until the output register frees up.
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/cor_checker.sv =====
// Port-level checks for the circle overlay rasterizer, bound to the top level.
`timescale 1ns / 1ps

module cor_checker import cor_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [CHAR_W-1:0] rsp_pixel_char,
	input logic [STAT_W-1:0] rsp_status,
	input logic              cfg_valid,
	input logic              cfg_ready
);

	// One request at a time: taking a request drops ready on the next cycle.
	a_req_single: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request side stayed ready after taking a request");

	// Only a successful query carries a character.
	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_OK) |-> (rsp_pixel_char == '0))
		else $error("nonzero character on a failed response");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_char) && $stable(rsp_status))
		else $error("stalled response changed or dropped");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write was stalled");

endmodule

bind circle_overlay_rasterizer_top cor_checker u_cor_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_pixel_char (rsp.pixel_char),
	.rsp_status     (rsp.status),
	.cfg_valid      (cfg.valid),
	.cfg_ready      (cfg.ready)
);
